// ===== rtl/sdmm_pkg.sv =====
// shared constants and types for the signed division magic multiplier unit
// no dependencies; imported by every module of the block

package sdmm_pkg;

   // word size of the signed division being replaced
   localparam int WORD_BITS     = 32;
   // divisor is positive, so one bit narrower than the word
   localparam int DIVISOR_BITS  = WORD_BITS - 1;
   // dividend 2^(WORD_BITS+l) plus 2^(l+1) fits in twice the word
   localparam int DIVIDEND_BITS = 2 * WORD_BITS;
   // both quotients stay below 2^(WORD_BITS+2)
   localparam int QUOT_BITS     = WORD_BITS + 2;
   localparam int MAGIC_BITS    = WORD_BITS + 1;
   localparam int SHIFT_BITS    = $clog2(WORD_BITS);
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);
   localparam int EXP_BITS      = $clog2(DIVIDEND_BITS);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_DIV_LOW,
      ST_WAIT_LOW,
      ST_DIV_HIGH,
      ST_WAIT_HIGH,
      ST_REDUCE,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/sdmm_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on sdmm_pkg for the operand widths

module sdmm_divider
   import sdmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [QUOT_BITS-1:0]     quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;

   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;
   logic                     last_step;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff      = trial - {1'b0, div_ff};
      fits      = trial >= {1'b0, div_ff};
      last_step = step_ff == STEP_BITS'(DIVIDEND_BITS - 1);
   end

   // next values: load on start, otherwise one restoring step while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUOT_BITS-1:0];

endmodule

// ===== rtl/signed_div_magic_multiplier_unit.sv =====
// magic multiplier unit for signed division by a positive constant divisor
// from accept to result strobe it finds l = ceil(log2 divisor), runs the low and the
// high division on the shared restoring divider, then r halving steps; a zero divisor
// goes straight to finish; the two divider passes dominate; busy high meanwhile
// one item at a time: a start is taken only in idle; the receiver cannot stall
// reset: synchronous active high, returns the sequencer to idle, no result pending

module signed_div_magic_multiplier_unit
   import sdmm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [DIVISOR_BITS-1:0] req_divisor,
   output logic                    rsp_valid,
   output logic [SHIFT_BITS-1:0]   rsp_post_shift,
   output logic [MAGIC_BITS-1:0]   rsp_magic_multiplier,
   output logic [SHIFT_BITS-1:0]   rsp_log2_ceiling
);

   state_type state_ff, state_in;

   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_BITS-1:0]  scan_ff, scan_in;
   logic [SHIFT_BITS-1:0]    log_ff, log_in;
   logic [SHIFT_BITS-1:0]    shift_ff, shift_in;
   logic [QUOT_BITS-1:0]     mlow_ff, mlow_in;
   logic [QUOT_BITS-1:0]     mhigh_ff, mhigh_in;

   logic                     div_start;
   logic [DIVIDEND_BITS-1:0] div_dividend;
   logic                     div_done;
   logic [QUOT_BITS-1:0]     div_quotient;
   logic [DIVIDEND_BITS-1:0] num_low;
   logic [DIVIDEND_BITS-1:0] num_bump;
   logic                     can_reduce;
   logic                     accept;

   assign accept = start && (state_ff == ST_IDLE);

   // dividends 2^(WORD_BITS+l) and 2^(WORD_BITS+l) + 2^(l+1)
   always_comb begin
      num_low  = DIVIDEND_BITS'(1) << (EXP_BITS'(WORD_BITS) + EXP_BITS'(log_ff));
      num_bump = DIVIDEND_BITS'(1) << (EXP_BITS'(log_ff) + EXP_BITS'(1));
   end

   // halving is allowed while the halves still differ and shift is nonzero
   assign can_reduce = (mlow_ff[QUOT_BITS-1:1] < mhigh_ff[QUOT_BITS-1:1])
                       && (shift_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_divisor == '0) ? ST_FINISH : ST_LOG;
            end
         end
         ST_LOG: begin
            if (scan_ff == '0) begin
               state_in = ST_DIV_LOW;
            end
         end
         ST_DIV_LOW:   state_in = ST_WAIT_LOW;
         ST_WAIT_LOW: begin
            if (div_done) begin
               state_in = ST_DIV_HIGH;
            end
         end
         ST_DIV_HIGH:  state_in = ST_WAIT_HIGH;
         ST_WAIT_HIGH: begin
            if (div_done) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!can_reduce) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and divider control per state
   always_comb begin
      divisor_in   = divisor_ff;
      scan_in      = scan_ff;
      log_in       = log_ff;
      shift_in     = shift_ff;
      mlow_in      = mlow_ff;
      mhigh_in     = mhigh_ff;
      div_start    = 1'b0;
      div_dividend = num_low;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               divisor_in = req_divisor;
               scan_in    = req_divisor - DIVISOR_BITS'(1);
               log_in     = '0;
               shift_in   = '0;
               mlow_in    = '0;
               mhigh_in   = '0;
            end
         end
         // bit length of (divisor - 1), one bit per cycle
         ST_LOG: begin
            if (scan_ff != '0) begin
               scan_in = scan_ff >> 1;
               log_in  = log_ff + SHIFT_BITS'(1);
            end
         end
         ST_DIV_LOW: begin
            div_start    = 1'b1;
            div_dividend = num_low;
         end
         ST_WAIT_LOW: begin
            if (div_done) begin
               mlow_in = div_quotient;
            end
         end
         ST_DIV_HIGH: begin
            div_start    = 1'b1;
            div_dividend = num_low + num_bump;
         end
         ST_WAIT_HIGH: begin
            if (div_done) begin
               mhigh_in = div_quotient;
               shift_in = log_ff;
            end
         end
         // halve both multipliers, one step per cycle
         ST_REDUCE: begin
            if (can_reduce) begin
               mlow_in  = mlow_ff >> 1;
               mhigh_in = mhigh_ff >> 1;
               shift_in = shift_ff - SHIFT_BITS'(1);
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      scan_ff    <= scan_in;
      log_ff     <= log_in;
      shift_ff   <= shift_in;
      mlow_ff    <= mlow_in;
      mhigh_ff   <= mhigh_in;
   end

   // shared divider, used once for each quotient
   sdmm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // result item is held in the datapath registers during the finish cycle
   assign busy                 = state_ff != ST_IDLE;
   assign rsp_valid            = state_ff == ST_FINISH;
   assign rsp_post_shift       = shift_ff;
   assign rsp_magic_multiplier = mhigh_ff[MAGIC_BITS-1:0];
   assign rsp_log2_ceiling     = log_ff;

endmodule
